// ===== rtl/core/yrfd_pkg.sv =====
// Package for the YUV to RGBA frame decimator.
// Payload structs, fixed-point coefficients and the keep-interval table.
// No dependencies.
`default_nettype none

package yrfd_pkg;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
    logic       frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_of_frame;
  } pix_out_t;

  typedef struct packed {
    logic    valid;
    pix_in_t data;
  } q_push_t;

  localparam int unsigned RateW = 5;

  // Coefficients with 16 fractional bits
  localparam logic signed [17:0] CoefRv = 18'sd89831;
  localparam logic signed [17:0] CoefGv = 18'sd45744;
  localparam logic signed [17:0] CoefGu = 18'sd22127;
  localparam logic signed [17:0] CoefBu = 18'sd113538;

  localparam logic [7:0] FullScale = 8'hFF;
  localparam logic [RateW-1:0] IntervalReset = 5'd30;

  // Keep interval 30 / rate, with the rate saturated to 1..30
  function automatic logic [RateW-1:0] keep_interval(input logic [RateW-1:0] rate);
    logic [RateW-1:0] res;
    res = 5'd1;
    case (rate) inside
      5'd0, 5'd1:     res = 5'd30;
      5'd2:           res = 5'd15;
      5'd3:           res = 5'd10;
      5'd4:           res = 5'd7;
      5'd5:           res = 5'd6;
      5'd6:           res = 5'd5;
      5'd7:           res = 5'd4;
      [5'd8:5'd10]:   res = 5'd3;
      [5'd11:5'd15]:  res = 5'd2;
      default:        res = 5'd1;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/yuv_to_rgba_frame_decimator.sv =====
// YUV to RGBA converter with whole-frame decimation; top level.
// Throughput: one pixel per cycle while the queue has room, dropped frames included.
// Pipeline: queue, multiply stage, sum/clamp output register.
// Reset clears the frame phase, the queue and pipeline valids; the rate resets to 1.
// Depends on yrfd_pkg, yrfd_front, yrfd_queue, yrfd_back.
`default_nettype none

module yuv_to_rgba_frame_decimator #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire  [yrfd_pkg::RateW-1:0] cfg_data_i,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  yrfd_pkg::pix_in_t          in_data_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output yrfd_pkg::pix_out_t         out_data_o
);
  import yrfd_pkg::*;

  q_push_t push;
  logic    q_ready, q_valid, q_pop;
  pix_in_t q_data;

  yrfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_ready_i   (q_ready),
    .push_o      (push)
  );

  yrfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  yrfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/yrfd_front.sv =====
// Front end: rate register, frame phase tracking and frame keep/drop decision.
// Depends on yrfd_pkg.
`default_nettype none

module yrfd_front (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire  [yrfd_pkg::RateW-1:0] cfg_data_i,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  yrfd_pkg::pix_in_t       in_data_i,
  input  wire                     q_ready_i,
  output yrfd_pkg::q_push_t       push_o
);
  import yrfd_pkg::*;

  logic [RateW-1:0] interval_q, interval_d;
  logic [RateW-1:0] phase_q, phase_d;
  logic [RateW-1:0] phase_inc;
  logic             accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = q_ready_i;
  assign accept      = in_valid_i & q_ready_i;
  assign phase_inc   = phase_q + 5'd1;

  always_comb begin
    interval_d = interval_q;
    if (cfg_valid_i) begin
      interval_d = keep_interval(cfg_data_i);
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (accept && in_data_i.frame_end) begin
      phase_d = (phase_inc >= interval_q) ? '0 : phase_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IntervalReset;
      phase_q    <= '0;
    end else begin
      interval_q <= interval_d;
      phase_q    <= phase_d;
    end
  end

  assign push_o.valid = accept && (phase_q == '0);
  assign push_o.data  = in_data_i;

endmodule

`default_nettype wire

// ===== rtl/core/yrfd_queue.sv =====
// Short queue between front end and conversion pipeline.
// Depends on yrfd_pkg.
`default_nettype none

module yrfd_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  yrfd_pkg::q_push_t  push_i,
  output logic               ready_o,
  output logic               valid_o,
  output yrfd_pkg::pix_in_t  data_o,
  input  wire                pop_i
);
  import yrfd_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt = CntW'(Depth);

  pix_in_t          storage_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != FullCnt);
  assign valid_o = (count_q != '0);
  assign data_o  = storage_q[rd_ptr_q];
  assign do_push = push_i.valid & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      storage_q[wr_ptr_q] <= push_i.data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/yrfd_back.sv =====
// Conversion pipeline: constant multiplies, then sum, floor, clamp into the output register.
// Depends on yrfd_pkg.
`default_nettype none

module yrfd_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_valid_i,
  input  yrfd_pkg::pix_in_t  q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output yrfd_pkg::pix_out_t out_data_o
);
  import yrfd_pkg::*;

  function automatic logic [7:0] clamp_chan(input logic signed [27:0] acc);
    logic [7:0] res;
    if (acc[27]) begin
      res = 8'd0;
    end else if (|acc[26:24]) begin
      res = FullScale;
    end else begin
      res = acc[23:16];
    end
    return res;
  endfunction

  logic signed [8:0]  u_c, v_c;
  logic signed [26:0] rv_d, gv_d, gu_d, bu_d;
  logic signed [26:0] rv_q, gv_q, gu_q, bu_q;
  logic [7:0]         y_q;
  logic               last_q;
  logic               s1_valid_q, out_valid_q;
  logic               s1_ready, s2_ready;
  logic signed [27:0] base, r_sum, g_sum, b_sum;
  pix_out_t           out_q, out_d;

  assign s2_ready = !out_valid_q || out_ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign pop_o    = q_valid_i && s1_ready;

  // sample minus 128 in two's complement
  assign u_c = {~q_data_i.blue_diff[7], ~q_data_i.blue_diff[7], q_data_i.blue_diff[6:0]};
  assign v_c = {~q_data_i.red_diff[7], ~q_data_i.red_diff[7], q_data_i.red_diff[6:0]};

  assign rv_d = 27'(CoefRv) * 27'(v_c);
  assign gv_d = 27'(CoefGv) * 27'(v_c);
  assign gu_d = 27'(CoefGu) * 27'(u_c);
  assign bu_d = 27'(CoefBu) * 27'(u_c);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rv_q   <= rv_d;
      gv_q   <= gv_d;
      gu_q   <= gu_d;
      bu_q   <= bu_d;
      y_q    <= q_data_i.luma;
      last_q <= q_data_i.frame_end;
    end
  end

  assign base  = $signed({4'b0000, y_q, 16'h0000});
  assign r_sum = base + 28'(rv_q);
  assign g_sum = base - 28'(gv_q) - 28'(gu_q);
  assign b_sum = base + 28'(bu_q);

  always_comb begin
    out_d.red           = clamp_chan(r_sum);
    out_d.green         = clamp_chan(g_sum);
    out_d.blue          = clamp_chan(b_sum);
    out_d.alpha         = FullScale;
    out_d.last_of_frame = last_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= q_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== tb/tb_yuv_to_rgba_frame_decimator.sv =====
// Self-checking testbench for yuv_to_rgba_frame_decimator: YUV to RGBA conversion and
// whole-frame decimation, checked against a fixed-point predictor under random stalls.
// Depends on yrfd_pkg and the yuv_to_rgba_frame_decimator RTL.
`timescale 1ns / 100ps

module tb_yuv_to_rgba_frame_decimator;
  import yrfd_pkg::*;

  class rgba_scoreboard;
    localparam int RvGain = 89831;
    localparam int GvGain = 45744;
    localparam int GuGain = 22127;
    localparam int BuGain = 113538;
    localparam int ChromaMid = 128;
    localparam int MaxRate = 30;

    pix_out_t rgba_due_q[$];
    logic [RateW-1:0] rate;
    logic [RateW-1:0] phase;
    int errors;

    function new();
      rate = 5'd1;
      phase = '0;
      errors = 0;
    endfunction

    function void set_rate(logic [RateW-1:0] value);
      if (value == 0) begin
        rate = 5'd1;
      end else if (value > MaxRate) begin
        rate = 5'(MaxRate);
      end else begin
        rate = value;
      end
    endfunction

    // floor by arithmetic shift, then clamp to a byte
    function logic [7:0] clamp_channel(int acc);
      int whole;
      whole = acc >>> 16;
      if (whole < 0) return 8'd0;
      if (whole > 255) return 8'd255;
      return 8'(whole);
    endfunction

    function void note_pixel(pix_in_t pix);
      int luma;
      int u_off;
      int v_off;
      int interval;
      int nxt;
      bit keep;
      pix_out_t rgba;
      interval = MaxRate / int'(rate);
      keep = (phase == 0);
      if (pix.frame_end) begin
        nxt = int'(phase) + 1;
        phase = (nxt >= interval) ? '0 : 5'(nxt);
      end
      if (keep) begin
        luma = int'(pix.luma) * 65536;
        u_off = int'(pix.blue_diff) - ChromaMid;
        v_off = int'(pix.red_diff) - ChromaMid;
        rgba.red = clamp_channel(luma + RvGain * v_off);
        rgba.green = clamp_channel(luma - GvGain * v_off - GuGain * u_off);
        rgba.blue = clamp_channel(luma + BuGain * u_off);
        rgba.alpha = 8'hFF;
        rgba.last_of_frame = pix.frame_end;
        rgba_due_q.push_back(rgba);
      end
    endfunction

    task report(string msg);
      if (errors < 100) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_rgba(pix_out_t got);
      pix_out_t want;
      if (rgba_due_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = rgba_due_q.pop_front();
      if (got.red !== want.red)
        report($sformatf("red got %0d expected %0d", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green got %0d expected %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue got %0d expected %0d", got.blue, want.blue));
      if (got.alpha !== want.alpha)
        report($sformatf("alpha got %0d expected %0d", got.alpha, want.alpha));
      if (got.last_of_frame !== want.last_of_frame)
        report($sformatf("last_of_frame got %0b expected %0b",
                         got.last_of_frame, want.last_of_frame));
    endtask

    function int pending();
      return rgba_due_q.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [RateW-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  pix_in_t          in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  pix_out_t         out_data_o;

  rgba_scoreboard sb;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  int frame_left = 0;

  yuv_to_rgba_frame_decimator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_rgba(out_data_o);
  end

  // receiver: random stall bursts, one long hold on request, none in the quiet tail
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready_i <= 1'b0;
        repeat (150) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  function automatic pix_in_t make_pixel(int y, int u, int v, bit last);
    pix_in_t pix;
    pix.luma = 8'(y);
    pix.blue_diff = 8'(u);
    pix.red_diff = 8'(v);
    pix.frame_end = last;
    return pix;
  endfunction

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_in_t next_pixel();
    pix_in_t pix;
    if (frame_left == 0) frame_left = $urandom_range(1, 8);
    pix.luma = rand_sample();
    pix.blue_diff = rand_sample();
    pix.red_diff = rand_sample();
    pix.frame_end = (frame_left == 1);
    frame_left--;
    return pix;
  endfunction

  task automatic push_pixel(input pix_in_t pix);
    in_valid_i <= 1'b1;
    in_data_i <= pix;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_pixel(pix);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // dropped pixels leave no trace, so allow the pipeline to empty before the write
  task automatic write_rate(input logic [RateW-1:0] value);
    drain_results();
    repeat (10) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_rate(value);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_frames(input int count, input int idle_odds);
    repeat (count) begin
      if (!quiet && idle_odds > 0 && $urandom_range(1, idle_odds) == 1) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      push_pixel(next_pixel());
    end
  endtask

  initial begin
    int rate_plan [11];
    int rate_pick;
    int odds_pick;
    rate_plan = '{0, 2, 31, 7, 16, 1, 30, 3, -1, -1, -1};
    sb = new();
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset rate keeps only the first of every 30 frames
    push_pixel(make_pixel(0, 128, 128, 0));
    push_pixel(make_pixel(255, 128, 128, 0));
    push_pixel(make_pixel(0, 0, 0, 0));
    push_pixel(make_pixel(255, 255, 255, 0));
    push_pixel(make_pixel(0, 255, 0, 0));
    push_pixel(make_pixel(255, 0, 255, 0));
    push_pixel(make_pixel(128, 0, 255, 0));
    push_pixel(make_pixel(128, 255, 0, 0));
    push_pixel(make_pixel(16, 128, 128, 0));
    push_pixel(make_pixel(235, 240, 16, 0));
    push_pixel(make_pixel(81, 90, 240, 0));
    push_pixel(make_pixel(255, 255, 0, 1));
    push_pixel(make_pixel(90, 200, 30, 0));
    push_pixel(make_pixel(10, 60, 200, 1));
    push_pixel(make_pixel(200, 10, 250, 0));
    push_pixel(make_pixel(50, 240, 5, 0));
    // rate change mid-frame with phase past the new interval
    write_rate(5'd31);
    push_pixel(make_pixel(77, 33, 199, 0));
    push_pixel(make_pixel(140, 170, 90, 1));
    push_pixel(make_pixel(255, 0, 0, 0));
    push_pixel(make_pixel(0, 255, 255, 0));
    push_pixel(make_pixel(128, 128, 128, 1));

    foreach (rate_plan[i]) begin
      rate_pick = (rate_plan[i] < 0) ? $urandom_range(0, 31) : rate_plan[i];
      if (i == 10) quiet = 1'b1;
      write_rate(5'(rate_pick));
      if (i == 2) begin
        // start sending only once the receiver has begun its long hold
        long_hold = 1'b1;
        wait (long_hold == 1'b0);
        run_frames(20, 0);
        drain_results();
        run_frames(16, 3);
      end else if (quiet) begin
        run_frames(36, 0);
      end else begin
        odds_pick = $urandom_range(0, 2);
        run_frames(36, (odds_pick == 0) ? 0 : (odds_pick == 1) ? 2 : 5);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== yuv_to_rgba_frame_decimator.f =====
rtl/core/yrfd_pkg.sv
rtl/core/yrfd_front.sv
rtl/core/yrfd_queue.sv
rtl/core/yrfd_back.sv
rtl/core/yuv_to_rgba_frame_decimator.sv
tb/tb_yuv_to_rgba_frame_decimator.sv
